>>> hw/rtl/hsd_pkg.sv
// hierarchical state dispatch: shared types, codes and constants
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package hsd_pkg;

  localparam int ID_W     = 4;
  localparam int EV_W     = 4;
  localparam int ID_COUNT = 1 << ID_W;
  localparam int TR_DEPTH = 1 << (ID_W + EV_W);
  localparam int RES_W    = 5;
  // cap on kept entry and exit results per request
  localparam logic [RES_W-1:0] RES_MAX = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD_LINKS = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_START      = 2'd2,
    OP_EVENT      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_ENTRY     = 2'd0,
    ACT_EXIT      = 2'd1,
    ACT_HANDLED   = 2'd2,
    ACT_UNHANDLED = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_UPL,
    CMD_LOOK,
    CMD_CHECK,
    CMD_UPD,
    CMD_LCA,
    CMD_XINIT,
    CMD_EXIT,
    CMD_ENTER,
    CMD_DENT,
    CMD_DSTEP,
    CMD_FIN_H,
    CMD_FIN_U
  } cmd_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] state_id;
    logic [EV_W-1:0] event_id;
    logic [ID_W-1:0] parent_id;
    logic            parent_valid;
    logic [ID_W-1:0] child_id;
    logic            child_valid;
    logic [ID_W-1:0] dest_id;
    logic            dest_valid;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] acted_state;
    logic            last;
  } out_req_t;

  typedef struct packed {
    logic up_more;
    logic hit;
    logic self_loop;
    logic idx_last;
    logic lca_hit;
    logic idx_end;
    logic x_done;
    logic e_done;
    logic dr_more;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/hsd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hsd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/hsd_datapath.sv
// datapath: link tables, transition store, ancestor chains, walk counters
// and the result register; depends on hsd_pkg and hsd_ram
`timescale 1ns / 1ps

module hsd_datapath #(
  parameter int NUM_STATES = 16,
  parameter int NUM_EVENTS = 16,
  parameter int MAX_DEPTH  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  hsd_pkg::in_req_t  in_req_i,
  input  hsd_pkg::cmd_e     cmd_i,
  output hsd_pkg::status_t  status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsd_pkg::out_req_t out_req_o
);
  import hsd_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int TW = $clog2(TR_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [ID_W-1:0] root_q, cur_leaf_q;
  logic [EV_W-1:0] ev_q;
  logic            par_vld_q [ID_COUNT];
  logic [ID_W-1:0] par_id_q  [ID_COUNT];
  logic            chd_vld_q [ID_COUNT];
  logic [ID_W-1:0] chd_id_q  [ID_COUNT];
  logic            tv_q      [TR_DEPTH];
  logic            tvr_q;
  logic [ID_W-1:0] cl_q [MAX_DEPTH];
  logic [ID_W-1:0] cd_q [MAX_DEPTH];
  logic [CW-1:0]   nl_q, nd_q, idx_q, jdx_q, c_q, k_q, cnt_q;
  logic [ID_W-1:0] tail_q, dtail_q, dst_q, leaf_q;
  logic [RES_W-1:0] nres_q;
  logic            out_valid_q;
  out_req_t        out_q;

  logic [ID_W-1:0] cl_rd, cd_rd, par_addr, tr_rd;
  logic [CW-1:0]   jdx_dec, up_cnt, lca_j;
  logic            par_ok, chd_ok, up_more, lca_hit, in_range_ev;
  logic [TW-1:0]   tr_addr, tr_waddr;
  logic            tr_we, acc_links;
  logic            emit_en, emit_last, kept;
  logic [1:0]      emit_act;
  logic [ID_W-1:0] emit_st;

  // chain reads
  assign cl_rd   = cl_q[idx_q[AW-1:0]];
  assign jdx_dec = jdx_q - ONE_C;
  assign cd_rd   = cd_q[jdx_dec[AW-1:0]];

  // parent lookup, shared by both chain walks
  assign par_addr = (cmd_i == CMD_UPD) ? dtail_q : tail_q;
  assign up_cnt   = (cmd_i == CMD_UPD) ? nd_q : nl_q;
  assign par_ok   = par_vld_q[par_addr] && (int'(par_addr) < NUM_STATES);
  assign up_more  = par_ok && (up_cnt < DEPTH_C);
  assign chd_ok   = chd_vld_q[leaf_q] && (int'(leaf_q) < NUM_STATES);

  // transition store
  assign in_range_ev = int'(ev_q) < NUM_EVENTS;
  assign tr_addr  = {cl_rd, ev_q};
  assign tr_waddr = {in_req_i.state_id, in_req_i.event_id};
  assign tr_we    = (cmd_i == CMD_ACCEPT) && (in_req_i.operation == OP_LOAD_TRANS) &&
                    (int'(in_req_i.state_id) < NUM_STATES) &&
                    (int'(in_req_i.event_id) < NUM_EVENTS);
  assign acc_links = (cmd_i == CMD_ACCEPT) && (in_req_i.operation == OP_LOAD_LINKS) &&
                     (int'(in_req_i.state_id) < NUM_STATES);

  hsd_ram #(
    .WIDTH (ID_W),
    .DEPTH (TR_DEPTH)
  ) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (in_req_i.dest_id),
    .raddr_i (tr_addr),
    .rdata_o (tr_rd)
  );

  // common ancestor compare, lowest destination-chain level wins
  always_comb begin
    lca_hit = 1'b0;
    lca_j   = '0;
    for (int j = MAX_DEPTH - 1; j >= 1; j--) begin
      if ((CW'(j) < nd_q) && (cd_q[j] == cl_rd)) begin
        lca_hit = 1'b1;
        lca_j   = CW'(j);
      end
    end
  end

  // status to the controller
  always_comb begin
    status_o.up_more   = up_more;
    status_o.hit       = tvr_q;
    status_o.self_loop = (tr_rd == cl_rd);
    status_o.idx_last  = (idx_q == nl_q - ONE_C);
    status_o.lca_hit   = lca_hit;
    status_o.idx_end   = (idx_q >= nl_q);
    status_o.x_done    = (idx_q >= c_q);
    status_o.e_done    = (jdx_q <= ONE_C);
    status_o.dr_more   = chd_ok && (cnt_q < DEPTH_C);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // result selection
  always_comb begin
    emit_en   = 1'b1;
    emit_last = 1'b0;
    emit_act  = ACT_ENTRY;
    emit_st   = leaf_q;
    case (cmd_i)
      CMD_EXIT: begin
        emit_act = ACT_EXIT;
        emit_st  = cl_rd;
      end
      CMD_ENTER: emit_st = cd_rd;
      CMD_DENT:  emit_st = leaf_q;
      CMD_DSTEP: emit_st = chd_id_q[leaf_q];
      CMD_FIN_H: begin
        emit_act  = ACT_HANDLED;
        emit_last = 1'b1;
      end
      CMD_FIN_U: begin
        emit_act  = ACT_UNHANDLED;
        emit_st   = cur_leaf_q;
        emit_last = 1'b1;
      end
      default: emit_en = 1'b0;
    endcase
  end
  assign kept = emit_last || (nres_q < RES_MAX);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      cur_leaf_q  <= '0;
      out_valid_q <= 1'b0;
      nres_q      <= '0;
      tvr_q       <= 1'b0;
      nl_q        <= '0;
      nd_q        <= '0;
      idx_q       <= '0;
      jdx_q       <= '0;
      c_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < ID_COUNT; i++) begin
        par_vld_q[i] <= 1'b0;
        chd_vld_q[i] <= 1'b0;
      end
      for (int i = 0; i < TR_DEPTH; i++) begin
        tv_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (acc_links) begin
        par_vld_q[in_req_i.state_id] <= in_req_i.parent_valid;
        chd_vld_q[in_req_i.state_id] <= in_req_i.child_valid;
      end
      if (tr_we) begin
        tv_q[tr_waddr] <= in_req_i.dest_valid;
      end
      // result register
      if (emit_en && kept) begin
        out_valid_q <= 1'b1;
        if (!emit_last) begin
          nres_q <= nres_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_ACCEPT: begin
          nres_q <= '0;
          idx_q  <= '0;
          nl_q   <= ONE_C;
          cnt_q  <= ONE_C;
        end
        CMD_UPL: if (up_more) nl_q <= nl_q + ONE_C;
        CMD_LOOK: tvr_q <= tv_q[tr_addr] && (int'(cl_rd) < NUM_STATES) && in_range_ev;
        CMD_CHECK: begin
          idx_q <= idx_q + ONE_C;
          if (tvr_q) begin
            c_q  <= idx_q + ONE_C;
            k_q  <= ONE_C;
            nd_q <= ONE_C;
          end
        end
        CMD_UPD: if (up_more) nd_q <= nd_q + ONE_C;
        CMD_LCA: begin
          if (lca_hit) begin
            c_q <= idx_q;
            k_q <= lca_j;
          end else begin
            idx_q <= idx_q + ONE_C;
          end
        end
        CMD_XINIT: begin
          idx_q <= '0;
          jdx_q <= k_q;
          cnt_q <= k_q;
        end
        CMD_EXIT:  idx_q <= idx_q + ONE_C;
        CMD_ENTER: jdx_q <= jdx_dec;
        CMD_DSTEP: cnt_q <= cnt_q + ONE_C;
        CMD_FIN_H: cur_leaf_q <= leaf_q;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_links) begin
      par_id_q[in_req_i.state_id] <= in_req_i.parent_id;
      chd_id_q[in_req_i.state_id] <= in_req_i.child_id;
    end
    if (emit_en && kept) begin
      out_q.action      <= emit_act;
      out_q.acted_state <= emit_st;
      out_q.last        <= emit_last;
    end
    case (cmd_i)
      CMD_ACCEPT: begin
        ev_q     <= in_req_i.event_id;
        tail_q   <= cur_leaf_q;
        leaf_q   <= root_q;
        cl_q[0]  <= cur_leaf_q;
      end
      CMD_UPL: begin
        if (up_more) begin
          tail_q                 <= par_id_q[par_addr];
          cl_q[nl_q[AW-1:0]]     <= par_id_q[par_addr];
        end
      end
      CMD_CHECK: begin
        if (tvr_q) begin
          dst_q   <= tr_rd;
          dtail_q <= tr_rd;
          cd_q[0] <= tr_rd;
        end
      end
      CMD_UPD: begin
        if (up_more) begin
          dtail_q                <= par_id_q[par_addr];
          cd_q[nd_q[AW-1:0]]     <= par_id_q[par_addr];
        end
      end
      CMD_XINIT: leaf_q <= dst_q;
      CMD_DSTEP: leaf_q <= chd_id_q[leaf_q];
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // final result of a request is always a status, and only a status
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == ((out_q.action == ACT_HANDLED) ||
                                    (out_q.action == ACT_UNHANDLED))))
    else $error("last flag does not match status action");

  // kept result count never passes the cap
  a_res_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= RES_MAX)
    else $error("result count above cap");

  // exits only walk the recorded leaf chain
  a_exit_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EXIT) |-> (idx_q < nl_q))
    else $error("exit beyond leaf chain");

endmodule

>>> hw/rtl/hsd_ctrl.sv
// controller: sequences the walks of one request through datapath commands
// depends on hsd_pkg
`timescale 1ns / 1ps

module hsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_op_i,
  output logic             in_ready_o,
  input  hsd_pkg::status_t status_i,
  output hsd_pkg::cmd_e    cmd_o
);
  import hsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPL, S_LOOK, S_CHECK, S_UPD, S_LCA, S_XINIT,
    S_EXIT, S_ENTER, S_DENT, S_DSTEP, S_FIN_H, S_FIN_U
  } state_e;

  state_e state_q, state_d;

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = CMD_ACCEPT;
          if (in_op_i == OP_START) begin
            state_d = S_DENT;
          end else if (in_op_i == OP_EVENT) begin
            state_d = S_UPL;
          end
        end
      end
      S_UPL: begin
        cmd_o = CMD_UPL;
        if (!status_i.up_more) state_d = S_LOOK;
      end
      S_LOOK: begin
        cmd_o   = CMD_LOOK;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o = CMD_CHECK;
        if (status_i.hit) begin
          state_d = status_i.self_loop ? S_XINIT : S_UPD;
        end else if (status_i.idx_last) begin
          state_d = S_FIN_U;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_UPD: begin
        cmd_o = CMD_UPD;
        if (!status_i.up_more) state_d = S_LCA;
      end
      S_LCA: begin
        if (status_i.idx_end) begin
          state_d = S_FIN_U;
        end else begin
          cmd_o = CMD_LCA;
          if (status_i.lca_hit) state_d = S_XINIT;
        end
      end
      S_XINIT: begin
        cmd_o   = CMD_XINIT;
        state_d = S_EXIT;
      end
      S_EXIT: begin
        if (status_i.x_done) begin
          state_d = S_ENTER;
        end else if (status_i.out_free) begin
          cmd_o = CMD_EXIT;
        end
      end
      S_ENTER: begin
        if (status_i.e_done) begin
          state_d = S_DENT;
        end else if (status_i.out_free) begin
          cmd_o = CMD_ENTER;
        end
      end
      S_DENT: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_DENT;
          state_d = S_DSTEP;
        end
      end
      S_DSTEP: begin
        if (!status_i.dr_more) begin
          state_d = S_FIN_H;
        end else if (status_i.out_free) begin
          cmd_o = CMD_DSTEP;
        end
      end
      S_FIN_H: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_FIN_H;
          state_d = S_IDLE;
        end
      end
      S_FIN_U: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_FIN_U;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // results are only issued into a free result register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o == CMD_EXIT) || (cmd_o == CMD_ENTER) || (cmd_o == CMD_DENT) ||
     (cmd_o == CMD_DSTEP) || (cmd_o == CMD_FIN_H) || (cmd_o == CMD_FIN_U))
    |-> status_i.out_free)
    else $error("result issued while result register busy");

  // a status result ends the request
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o == CMD_FIN_H) || (cmd_o == CMD_FIN_U)) |=> in_ready_o)
    else $error("not idle after status");

endmodule

>>> hw/rtl/hierarchical_state_dispatch_core.sv
// Hierarchical state machine dispatch engine, top level.
// A request on in_req_i (valid/ready) is one of: load state links, load a
// transition, start, or event. Loads give no result.
// Start enters root_state (cfg_we_i/cfg_wdata_i) and its initial children.
// An event walks the leaf's ancestors, looks up a handler one ancestor at a
// time in the transition ram, walks the destination's ancestors, finds
// the common ancestor one level a cycle, then gives exits, entries and a
// final status with last set on out_req_o (valid/ready).
// One request is in work at a time. The single result register stalls the
// walk while the receiver holds ready low; entry and exit results past
// RES_MAX per request are dropped. Reset clears all link and transition
// valid bits, the current leaf and root_state to state zero.
`timescale 1ns / 1ps

module hierarchical_state_dispatch_core #(
  parameter int NUM_STATES = 16,
  parameter int NUM_EVENTS = 16,
  parameter int MAX_DEPTH  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsd_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsd_pkg::out_req_t out_req_o
);
  import hsd_pkg::*;

  cmd_e    cmd;
  status_t status;

  // sequencer
  hsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_req_i.operation),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tables, chains and result register
  hsd_datapath #(
    .NUM_STATES (NUM_STATES),
    .NUM_EVENTS (NUM_EVENTS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> tb/tb_top.sv
// hierarchical state dispatch testbench: directed and random requests with a
// scoreboard that predicts every result; depends on hsd_pkg and the core
`timescale 1ns / 1ps

module tb_top;
  import hsd_pkg::*;

class dispatch_scoreboard;
  logic [4:0] parent_tab [16];
  logic [4:0] child_tab [16];
  logic [4:0] trans_tab [256];
  logic [3:0] leaf;
  logic [3:0] root;
  out_req_t   pending_q[$];
  int         errors;
  out_req_t   burst_q[$];

  function void clear();
    for (int i = 0; i < 16; i++) begin
      parent_tab[i] = '0;
      child_tab[i]  = '0;
    end
    for (int i = 0; i < 256; i++) trans_tab[i] = '0;
    leaf = '0;
    root = '0;
    pending_q.delete();
    errors = 0;
  endfunction

  function void push_result(act_e act, logic [3:0] st);
    out_req_t r;
    if (burst_q.size() >= 16) return;
    r.action      = act;
    r.acted_state = st;
    r.last        = 1'b0;
    burst_q.insert(burst_q.size(), r);
  endfunction

  function void close_burst(act_e act);
    out_req_t r;
    r.action      = act;
    r.acted_state = leaf;
    r.last        = 1'b1;
    burst_q.insert(burst_q.size(), r);
    foreach (burst_q[i]) pending_q.insert(pending_q.size(), burst_q[i]);
    burst_q.delete();
  endfunction

  // ancestors of s, s first, at most 8
  function int ancestors(logic [3:0] s, ref logic [3:0] chain [8]);
    int n;
    n = 1;
    chain[0] = s;
    while (n < 8 && parent_tab[chain[n-1]][4]) begin
      chain[n] = parent_tab[chain[n-1]][3:0];
      n++;
    end
    return n;
  endfunction

  function logic [3:0] enter_down(logic [3:0] s, int count);
    logic [3:0] cur;
    cur = s;
    push_result(ACT_ENTRY, cur);
    while (count < 8 && child_tab[cur][4]) begin
      cur = child_tab[cur][3:0];
      push_result(ACT_ENTRY, cur);
      count++;
    end
    return cur;
  endfunction

  function void note_request(in_req_t q);
    logic [3:0] lc [8];
    logic [3:0] dc [8];
    int nl, nd, h, c, k;
    logic [3:0] d;
    logic hit;
    case (op_e'(q.operation))
      OP_LOAD_LINKS: begin
        parent_tab[q.state_id] = q.parent_valid ? {1'b1, q.parent_id} : 5'd0;
        child_tab[q.state_id]  = q.child_valid ? {1'b1, q.child_id} : 5'd0;
      end
      OP_LOAD_TRANS:
        trans_tab[{q.state_id, q.event_id}] = q.dest_valid ? {1'b1, q.dest_id} : 5'd0;
      OP_START: begin
        leaf = enter_down(root, 1);
        close_burst(ACT_HANDLED);
      end
      default: begin
        nl = ancestors(leaf, lc);
        hit = 1'b0;
        h = 0;
        d = '0;
        for (int i = 0; i < nl && !hit; i++) begin
          if (trans_tab[{lc[i], q.event_id}][4]) begin
            hit = 1'b1;
            h = i;
            d = trans_tab[{lc[i], q.event_id}][3:0];
          end
        end
        if (!hit) begin
          close_burst(ACT_UNHANDLED);
          return;
        end
        c = 0;
        k = 0;
        if (d == lc[h]) begin
          c = h + 1;
          k = 1;
        end else begin
          hit = 1'b0;
          nd = ancestors(d, dc);
          for (int i = h + 1; i < nl && !hit; i++) begin
            for (int j = 1; j < nd && !hit; j++) begin
              if (lc[i] == dc[j]) begin
                c = i;
                k = j;
                hit = 1'b1;
              end
            end
          end
          if (!hit) begin
            close_burst(ACT_UNHANDLED);
            return;
          end
        end
        for (int i = 0; i < c && i < nl; i++) push_result(ACT_EXIT, lc[i]);
        for (int j = k; j > 1; j--) push_result(ACT_ENTRY, dc[j-1]);
        leaf = enter_down(d, k);
        close_burst(ACT_HANDLED);
      end
    endcase
  endfunction

  function void check_result(out_req_t got);
    out_req_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result act=%0d st=%0d last=%0d", $time,
               got.action, got.acted_state, got.last);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.action !== exp_r.action) begin
      $display("%0t: action exp %0d got %0d", $time, exp_r.action, got.action);
      errors++;
    end
    if (got.acted_state !== exp_r.acted_state) begin
      $display("%0t: acted_state exp %0d got %0d", $time, exp_r.acted_state,
               got.acted_state);
      errors++;
    end
    if (got.last !== exp_r.last) begin
      $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
      errors++;
    end
  endfunction
endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;

  dispatch_scoreboard sb;
  bit long_hold = 1'b0;

  hierarchical_state_dispatch_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_req_o(out_req_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // send one request, holding valid until accepted; valid stays high after
  // acceptance so the next request can follow back to back
  task automatic send_req(in_req_t q);
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(q);
  endtask

  // random gap then request; bursts keep valid high
  int burst_left = 0;
  task automatic paced_send(in_req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    send_req(q);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_root(logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.root = v;
  endtask

  function automatic in_req_t links_req(logic [3:0] s, logic pv, logic [3:0] p,
                                        logic cv, logic [3:0] c);
    in_req_t q;
    q = in_req_t'($urandom);
    q.operation = OP_LOAD_LINKS;
    q.state_id = s;
    q.parent_valid = pv;
    q.parent_id = p;
    q.child_valid = cv;
    q.child_id = c;
    return q;
  endfunction

  function automatic in_req_t trans_req(logic [3:0] s, logic [3:0] e, logic dv,
                                        logic [3:0] d);
    in_req_t q;
    q = in_req_t'($urandom);
    q.operation = OP_LOAD_TRANS;
    q.state_id = s;
    q.event_id = e;
    q.dest_valid = dv;
    q.dest_id = d;
    return q;
  endfunction

  function automatic in_req_t op_req(op_e op, logic [3:0] e);
    in_req_t q;
    q = in_req_t'($urandom);
    q.operation = op;
    q.event_id = e;
    return q;
  endfunction

  // random tree: each state gets a parent of lower id, mostly
  task automatic build_tree();
    for (int s = 0; s < 16; s++) begin
      paced_send(links_req(4'(s), s != 0 && $urandom_range(0, 9) != 0,
                 s == 0 ? 4'($urandom) : 4'($urandom_range(0, s - 1)),
                 $urandom_range(0, 2) != 0, 4'($urandom)));
    end
  endtask

  // receiver: stall pattern plus one long hold
  initial begin
    int phase;
    phase = 0;
    while (1) begin
      @(posedge clk_i);
      phase++;
      if (long_hold) out_ready_i <= 1'b0;
      else if (phase % 64 < 20) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_req_o);
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int r;
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: event before start, empty start, chain of depth past the bound
    send_req(op_req(OP_EVENT, 4'd0));
    drain();
    write_root(4'd15);
    send_req(op_req(OP_START, 4'd0));
    for (int s = 1; s < 10; s++)
      send_req(links_req(4'(s), 1'b1, 4'(s - 1), 1'b1, 4'(s + 1)));
    send_req(links_req(4'd0, 1'b0, 4'd0, 1'b1, 4'd1));
    send_req(links_req(4'd15, 1'b1, 4'd15, 1'b1, 4'd15)); // self cycle
    drain();
    write_root(4'd0);
    send_req(op_req(OP_START, 4'd3));
    send_req(trans_req(4'd3, 4'd15, 1'b1, 4'd3));          // self-loop
    send_req(trans_req(4'd2, 4'd1, 1'b1, 4'd5));           // destination below the source
    send_req(trans_req(4'd6, 4'd0, 1'b1, 4'd15));          // no common ancestor
    send_req(op_req(OP_EVENT, 4'd15));
    send_req(op_req(OP_EVENT, 4'd1));
    send_req(op_req(OP_EVENT, 4'd0));
    send_req(trans_req(4'd6, 4'd0, 1'b0, 4'd0));
    send_req(op_req(OP_EVENT, 4'd0));
    drain();

    // random phases with several root settings
    for (int ph = 0; ph < 6; ph++) begin
      write_root(ph == 5 ? 4'd15 : 4'($urandom));
      build_tree();
      for (int t = 0; t < 12; t++)
        paced_send(trans_req(4'($urandom), 4'($urandom_range(0, 3)),
                   $urandom_range(0, 5) != 0, 4'($urandom)));
      paced_send(op_req(OP_START, 4'($urandom)));
      if (ph == 2) begin
        fork
          begin
            long_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            long_hold = 1'b0;
          end
        join_none
      end
      for (int t = 0; t < 22; t++) begin
        r = $urandom_range(0, 19);
        if (r < 14) paced_send(op_req(OP_EVENT, 4'($urandom_range(0, 3))));
        else if (r < 15) paced_send(op_req(OP_EVENT, 4'($urandom)));
        else if (r < 16) paced_send(op_req(OP_START, 4'($urandom)));
        else if (r < 18)
          paced_send(trans_req(4'($urandom), 4'($urandom_range(0, 3)),
                     1'($urandom), 4'($urandom)));
        else
          paced_send(links_req(4'($urandom), 1'($urandom), 4'($urandom),
                     1'($urandom), 4'($urandom)));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
